FILE: design/slr_pkg.sv
package slr_pkg;

  // Sample and phase formats
  localparam int SAMPLE_W = 16;
  localparam int STEP_W   = 19;
  localparam int FRAC_W   = 16;
  localparam int PROD_W   = 2 * (SAMPLE_W + 1);
  localparam int SUM_W    = PROD_W + 1;

  localparam logic [STEP_W-1:0] ONE_Q16  = STEP_W'(1 << FRAC_W);
  localparam int                HALF_LSB = 1 << (FRAC_W - 1);

  // Output frames per source frame, at most
  localparam int MAX_OUT = 16;
  localparam int CNT_W   = $clog2(MAX_OUT);

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // APB register map
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;
  localparam int REG_IDX_W = PADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_STEP = REG_IDX_W'(0);

  typedef enum logic [0:0] {
    KIND_INTERP = 1'b0,
    KIND_PASS   = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e                       kind;
    logic signed [SAMPLE_W-1:0]  left;
    logic signed [SAMPLE_W-1:0]  right;
  } cmd_t;

endpackage

FILE: design/slr_front.sv
module slr_front
  import slr_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // APB
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PADDR_W-1:0]   paddr,
  input  logic [PDATA_W-1:0]   pwdata,
  output logic [PDATA_W-1:0]   prdata,
  output logic                 pready,
  // source frames
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic signed [SAMPLE_W-1:0] left_in_i,
  input  logic signed [SAMPLE_W-1:0] right_in_i,
  // to queue
  output logic                 push_o,
  input  logic                 push_ready_i,
  output cmd_t                 cmd_o,
  // to back end
  output logic [STEP_W-1:0]    step_o,
  output logic                 clr_o
);

  logic [STEP_W-1:0]    step_q, step_d;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_step;

  assign reg_idx = paddr[PADDR_W-1:2];
  assign pready  = 1'b1;
  assign wr_step = psel && penable && pwrite && (reg_idx == REG_STEP);

  always_comb begin
    step_d = step_q;
    if (wr_step) begin
      step_d = pwdata[STEP_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= ONE_Q16;
    end else begin
      step_q <= step_d;
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == REG_STEP) begin
      prdata = PDATA_W'(step_q);
    end
  end

  // unity step passes frames straight through
  always_comb begin
    cmd_o.kind  = (step_q == ONE_Q16) ? KIND_PASS : KIND_INTERP;
    cmd_o.left  = left_in_i;
    cmd_o.right = right_in_i;
  end

  assign push_o     = in_valid_i && push_ready_i;
  assign in_stall_o = !push_ready_i;
  assign step_o     = step_q;
  assign clr_o      = wr_step;

endmodule

FILE: design/slr_fifo.sv
module slr_fifo
  import slr_pkg::*;
#(
  parameter int Width = 33,
  parameter int Depth = QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             ready_o,
  input  logic [Width-1:0] data_i,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [Width-1:0] data_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign ready_o = (cnt_q != CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

FILE: design/slr_back.sv
module slr_back
  import slr_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [STEP_W-1:0]          step_i,
  input  logic                       clr_i,
  input  logic                       cmd_valid_i,
  input  cmd_t                       cmd_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [SAMPLE_W-1:0] left_out_o,
  output logic signed [SAMPLE_W-1:0] right_out_o,
  output logic                       last_o
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_e;

  state_e state_q, state_d;

  // resampler state
  logic [STEP_W-1:0]          phase_q, phase_d;
  logic signed [SAMPLE_W-1:0] prev_l_q, prev_l_d, prev_r_q, prev_r_d;
  logic                       prev_vld_q, prev_vld_d;
  // item in progress
  logic signed [SAMPLE_W-1:0] cur_l_q, cur_l_d, cur_r_q, cur_r_d;
  logic [STEP_W-1:0]          ph_q, ph_d;
  logic [CNT_W-1:0]           cnt_q, cnt_d;

  // product stage
  logic                       p_vld_q;
  logic signed [PROD_W-1:0]   p_prod_l_q, p_prod_r_q;
  logic signed [SAMPLE_W-1:0] p_a_l_q, p_a_r_q;
  logic                       p_last_q;
  // output stage
  logic                       o_vld_q;
  logic signed [SAMPLE_W-1:0] o_l_q, o_r_q;
  logic                       o_last_q;

  // issue operands
  logic                       issue, iss_last;
  logic signed [SAMPLE_W-1:0] a_l, a_r, b_l, b_r;
  logic [FRAC_W-1:0]          frac;
  logic signed [SAMPLE_W:0]   d_l, d_r, frac_s;
  logic signed [PROD_W-1:0]   prod_l, prod_r;
  logic signed [SUM_W-1:0]    sum_l, sum_r;

  logic [STEP_W:0]            ph_next;
  logic                       ph_ge_one, next_ge_one;
  logic                       o_ld, p_free;

  assign o_ld   = p_vld_q && (!o_vld_q || !out_stall_i);
  assign p_free = !p_vld_q || o_ld;

  assign ph_next     = {1'b0, ph_q} + {1'b0, step_i};
  assign ph_ge_one   = (ph_q >= ONE_Q16);
  assign next_ge_one = (ph_next >= {1'b0, ONE_Q16});

  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    prev_l_d   = prev_l_q;
    prev_r_d   = prev_r_q;
    prev_vld_d = prev_vld_q;
    cur_l_d    = cur_l_q;
    cur_r_d    = cur_r_q;
    ph_d       = ph_q;
    cnt_d      = cnt_q;
    pop_o      = 1'b0;
    issue      = 1'b0;
    iss_last   = 1'b0;
    a_l        = prev_l_q;
    a_r        = prev_r_q;
    b_l        = cur_l_q;
    b_r        = cur_r_q;
    frac       = ph_q[FRAC_W-1:0];

    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          if (cmd_i.kind == KIND_PASS) begin
            if (p_free) begin
              pop_o      = 1'b1;
              issue      = 1'b1;
              iss_last   = 1'b1;
              a_l        = cmd_i.left;
              a_r        = cmd_i.right;
              b_l        = cmd_i.left;
              b_r        = cmd_i.right;
              frac       = '0;
              prev_l_d   = cmd_i.left;
              prev_r_d   = cmd_i.right;
              prev_vld_d = 1'b1;
            end
          end else if (!prev_vld_q) begin
            // first frame only primes the history
            pop_o      = 1'b1;
            prev_l_d   = cmd_i.left;
            prev_r_d   = cmd_i.right;
            prev_vld_d = 1'b1;
          end else begin
            pop_o   = 1'b1;
            cur_l_d = cmd_i.left;
            cur_r_d = cmd_i.right;
            ph_d    = phase_q;
            cnt_d   = '0;
            state_d = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        if (ph_ge_one) begin
          // decimation: frame skipped
          phase_d  = ph_q - ONE_Q16;
          prev_l_d = cur_l_q;
          prev_r_d = cur_r_q;
          state_d  = ST_IDLE;
        end else if (p_free) begin
          issue    = 1'b1;
          iss_last = next_ge_one || (cnt_q == CNT_W'(MAX_OUT - 1));
          if (iss_last) begin
            phase_d  = next_ge_one ? STEP_W'(ph_next - {1'b0, ONE_Q16})
                                   : ph_next[STEP_W-1:0];
            prev_l_d = cur_l_q;
            prev_r_d = cur_r_q;
            state_d  = ST_IDLE;
          end else begin
            ph_d  = ph_next[STEP_W-1:0];
            cnt_d = cnt_q + CNT_W'(1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (clr_i) begin
      phase_d    = '0;
      prev_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      phase_q    <= '0;
      prev_l_q   <= '0;
      prev_r_q   <= '0;
      prev_vld_q <= 1'b0;
      p_vld_q    <= 1'b0;
      o_vld_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      phase_q    <= phase_d;
      prev_l_q   <= prev_l_d;
      prev_r_q   <= prev_r_d;
      prev_vld_q <= prev_vld_d;
      if (issue) begin
        p_vld_q <= 1'b1;
      end else if (o_ld) begin
        p_vld_q <= 1'b0;
      end
      if (o_ld) begin
        o_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        o_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_l_q <= cur_l_d;
    cur_r_q <= cur_r_d;
    ph_q    <= ph_d;
    cnt_q   <= cnt_d;
  end

  // stage 1: (b - a) * frac
  assign d_l    = {b_l[SAMPLE_W-1], b_l} - {a_l[SAMPLE_W-1], a_l};
  assign d_r    = {b_r[SAMPLE_W-1], b_r} - {a_r[SAMPLE_W-1], a_r};
  assign frac_s = $signed({1'b0, frac});
  assign prod_l = d_l * frac_s;
  assign prod_r = d_r * frac_s;

  always_ff @(posedge clk_i) begin
    if (issue) begin
      p_prod_l_q <= prod_l;
      p_prod_r_q <= prod_r;
      p_a_l_q    <= a_l;
      p_a_r_q    <= a_r;
      p_last_q   <= iss_last;
    end
  end

  // stage 2: a<<16 + product + half LSB, keep bits 31:16
  assign sum_l = SUM_W'($signed({p_a_l_q, {FRAC_W{1'b0}}})) + SUM_W'(p_prod_l_q)
               + SUM_W'(HALF_LSB);
  assign sum_r = SUM_W'($signed({p_a_r_q, {FRAC_W{1'b0}}})) + SUM_W'(p_prod_r_q)
               + SUM_W'(HALF_LSB);

  always_ff @(posedge clk_i) begin
    if (o_ld) begin
      o_l_q    <= sum_l[FRAC_W+SAMPLE_W-1:FRAC_W];
      o_r_q    <= sum_r[FRAC_W+SAMPLE_W-1:FRAC_W];
      o_last_q <= p_last_q;
    end
  end

  assign out_valid_o = o_vld_q;
  assign left_out_o  = o_l_q;
  assign right_out_o = o_r_q;
  assign last_o      = o_last_q;

endmodule

FILE: design/stereo_linear_resampler.sv
// Channel    | Dir | Handshake              | Beat payload
// -----------+-----+------------------------+--------------------------------------
// source     | in  | in_valid_i / in_stall_o | left_in_i, right_in_i (s16 each)
// resampled  | out | out_valid_o / out_stall_i | left_out_o, right_out_o (s16), last_o
// config     | in  | APB, pready always high | step_ratio at byte 0 (u3.16, 19 bits)
//
// A source beat enters the command queue at the edge that accepts it and can
// be popped at the next edge. For an interpolating frame the back end spends
// the pop cycle loading it, then, while the output does not stall, issues
// one output per cycle through a multiply stage and an output register, up
// to 16 per frame, back to back. A priming frame only fills the history; a
// skipped (decimated) frame is loaded, then dropped. A unity-step frame is
// popped and issued in the same cycle once the multiply stage is free.
// Reset sets step to 1.0 and clears phase, history and the queue.
// Either side may stall freely; the queue keeps accepting while the back end
// is busy or the output is held, and the input stalls once the queue is full.
module stereo_linear_resampler
  import slr_pkg::*;
#(
  parameter int QueueDepth = QUEUE_DEPTH
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // APB config
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [PADDR_W-1:0]         paddr,
  input  logic [PDATA_W-1:0]         pwdata,
  output logic [PDATA_W-1:0]         prdata,
  output logic                       pready,
  // source frames
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic signed [SAMPLE_W-1:0] left_in_i,
  input  logic signed [SAMPLE_W-1:0] right_in_i,
  // resampled frames
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [SAMPLE_W-1:0] left_out_o,
  output logic signed [SAMPLE_W-1:0] right_out_o,
  output logic                       last_o
);

  logic              push, push_ready, pop, q_valid, clr;
  cmd_t              cmd_in, cmd_out;
  logic [STEP_W-1:0] step;

  // front: register file, classify frame, push into queue
  slr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .left_in_i    (left_in_i),
    .right_in_i   (right_in_i),
    .push_o       (push),
    .push_ready_i (push_ready),
    .cmd_o        (cmd_in),
    .step_o       (step),
    .clr_o        (clr)
  );

  // short command queue decoupling the two halves
  slr_fifo #(
    .Width ($bits(cmd_t)),
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .ready_o (push_ready),
    .data_i  (cmd_in),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (cmd_out)
  );

  // back: phase walk, interpolation pipeline, output register
  slr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .clr_i       (clr),
    .cmd_valid_i (q_valid),
    .cmd_i       (cmd_out),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .left_out_o  (left_out_o),
    .right_out_o (right_out_o),
    .last_o      (last_o)
  );

endmodule

FILE: verif/slr_checker.sv
`timescale 1ns / 100ps

module slr_checker
  import slr_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic                       pready,
  input  logic [PADDR_W-1:0]         paddr,
  input  logic [PDATA_W-1:0]         pwdata,
  input  logic                       in_valid_i,
  input  logic                       in_stall_i,
  input  logic signed [SAMPLE_W-1:0] left_in_i,
  input  logic signed [SAMPLE_W-1:0] right_in_i,
  input  logic                       out_valid_i,
  input  logic                       out_stall_i,
  input  logic signed [SAMPLE_W-1:0] left_out_i,
  input  logic signed [SAMPLE_W-1:0] right_out_i,
  input  logic                       last_i,
  output int                         fail_cnt_o,
  output int                         pending_o,
  output int                         out_beats_o
);

  typedef struct {
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] right;
    logic                       last;
  } stereo_t;

  stereo_t                    resampled_q[$];
  logic [STEP_W-1:0]          step_q16;
  logic [STEP_W-1:0]          phase_q16;
  logic signed [SAMPLE_W-1:0] hist_left;
  logic signed [SAMPLE_W-1:0] hist_right;
  logic                       hist_valid;
  int                         fail_cnt;
  int                         out_beats;

  initial begin
    fail_cnt    = 0;
    out_beats   = 0;
  end

  // a + (b - a) * frac in 16.16, rounded half up, floor shift
  function automatic logic signed [SAMPLE_W-1:0] blend(input logic signed [SAMPLE_W-1:0] a,
                                                        input logic signed [SAMPLE_W-1:0] b,
                                                        input int unsigned frac);
    longint acc;
    acc = (longint'(a) <<< FRAC_W) + (longint'(b) - longint'(a)) * longint'(frac)
          + longint'(HALF_LSB);
    return SAMPLE_W'(acc >>> FRAC_W);
  endfunction

  function automatic void predict_resampled(input logic signed [SAMPLE_W-1:0] cur_l,
                                            input logic signed [SAMPLE_W-1:0] cur_r);
    int unsigned ph;
    int          n;
    stereo_t     f;
    if (step_q16 == ONE_Q16) begin
      f.left  = cur_l;
      f.right = cur_r;
      f.last  = 1'b1;
      resampled_q.push_back(f);
    end else if (hist_valid) begin
      ph = phase_q16;
      n  = 0;
      while (ph < ONE_Q16 && n < MAX_OUT) begin
        f.left  = blend(hist_left, cur_l, ph & 32'hFFFF);
        f.right = blend(hist_right, cur_r, ph & 32'hFFFF);
        n++;
        ph += step_q16;
        f.last = !(ph < ONE_Q16 && n < MAX_OUT);
        resampled_q.push_back(f);
      end
      if (ph >= ONE_Q16) ph -= ONE_Q16;
      phase_q16 = STEP_W'(ph);
    end
    hist_left  = cur_l;
    hist_right = cur_r;
    hist_valid = 1'b1;
  endfunction

  function automatic void check_field(input string name, input int exp_val, input int act_val);
    if (exp_val != act_val) begin
      fail_cnt++;
      $error("%s mismatch: expected %0d, actual %0d", name, exp_val, act_val);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    stereo_t want;
    if (!rst_ni) begin
      step_q16   = ONE_Q16;
      phase_q16  = '0;
      hist_left  = '0;
      hist_right = '0;
      hist_valid = 1'b0;
      resampled_q.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == {REG_STEP, 2'b00}) begin
        step_q16   = pwdata[STEP_W-1:0];
        phase_q16  = '0;
        hist_valid = 1'b0;
      end
      if (in_valid_i && !in_stall_i) predict_resampled(left_in_i, right_in_i);
      if (out_valid_i && !out_stall_i) begin
        out_beats++;
        if (resampled_q.size() == 0) begin
          fail_cnt++;
          $error("unexpected output beat: left_out %0d right_out %0d last %0b",
                 left_out_i, right_out_i, last_i);
        end else begin
          want = resampled_q.pop_front();
          check_field("left_out", int'(want.left), int'(left_out_i));
          check_field("right_out", int'(want.right), int'(right_out_i));
          check_field("last", int'(want.last), int'(last_i));
        end
      end
    end
    fail_cnt_o  <= fail_cnt;
    pending_o   <= resampled_q.size();
    out_beats_o <= out_beats;
  end

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import slr_pkg::*;

  // Cycles to let non-producing source beats (priming, skipped frames) drain
  // out of the command queue and back end before touching the step register.
  localparam int DRAIN_CYCLES = 40;
  // One long output hold so the queue fills and the source side stalls.
  localparam int LONG_HOLD    = 250;
  localparam int RAND_PHASES  = 12;
  localparam int PHASE_BEATS  = 34;

  logic                       clk_i   = 1'b0;
  logic                       rst_ni  = 1'b0;
  logic                       psel    = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite  = 1'b0;
  logic [PADDR_W-1:0]         paddr   = '0;
  logic [PDATA_W-1:0]         pwdata  = '0;
  logic [PDATA_W-1:0]         prdata;
  logic                       pready;
  logic                       in_valid  = 1'b0;
  logic                       in_stall;
  logic signed [SAMPLE_W-1:0] left_in   = '0;
  logic signed [SAMPLE_W-1:0] right_in  = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [SAMPLE_W-1:0] left_out;
  logic signed [SAMPLE_W-1:0] right_out;
  logic                       last_o;

  // 0: no idling; N: an idle burst starts with odds 1 in N per beat/cycle
  int gap_odds       = 0;
  bit want_long_hold = 1'b0;
  bit long_hold_done = 1'b0;

  int fail_cnt;
  int pending;
  int out_beats;
  int in_beats       = 0;
  int settings_used  = 0;

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  stereo_linear_resampler u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .left_in_i   (left_in),
    .right_in_i  (right_in),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .left_out_o  (left_out),
    .right_out_o (right_out),
    .last_o      (last_o)
  );

  slr_checker u_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .left_in_i   (left_in),
    .right_in_i  (right_in),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .left_out_i  (left_out),
    .right_out_i (right_out),
    .last_i      (last_o),
    .fail_cnt_o  (fail_cnt),
    .pending_o   (pending),
    .out_beats_o (out_beats)
  );

  // Output side: random stall bursts per gap_odds, plus the one long hold.
  // Each pass through the loop touches out_stall at most once per edge.
  initial begin
    forever begin
      @(posedge clk_i);
      if (want_long_hold && !long_hold_done) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
        out_stall      <= 1'b0;
        long_hold_done = 1'b1;
      end else if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
        out_stall <= 1'b0;
      end
    end
  end

  // Hard stop: far above the slowest legal run (16 beats per source beat,
  // each behind a max stall burst, plus gaps, drains and the long hold).
  initial begin
    #15_000_000;
    $display("FAILURE");
    $finish;
  end

  // APB write: setup cycle, then access; lands on the edge with pready high.
  task automatic write_step(input logic [PDATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_STEP, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    settings_used++;
  endtask

  // Only the low 19 bits matter; junk above them half the time.
  task automatic set_step(input logic [STEP_W-1:0] step);
    logic [PDATA_W-1:0] junk;
    junk = $urandom_range(0, 1) ? ($urandom & ~32'h7FFFF) : '0;
    write_step(junk | PDATA_W'(step));
  endtask

  // One source beat. Optional idle burst first (payload scrambled while
  // valid is low), then hold the beat until accepted. Valid stays high on
  // return so back-to-back beats need no re-raise.
  task automatic send_frame(input logic signed [SAMPLE_W-1:0] l,
                            input logic signed [SAMPLE_W-1:0] r);
    if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      in_valid <= 1'b0;
      left_in  <= SAMPLE_W'($urandom);
      right_in <= SAMPLE_W'($urandom);
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    left_in  <= l;
    right_in <= r;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    in_beats++;
  endtask

  // Close a phase: drop valid, wait for every predicted beat, then let
  // non-producing beats clear the pipe so the block is idle.
  task automatic end_phase();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Mix of full-range noise, rail values and small steps from the last one
  function automatic logic signed [SAMPLE_W-1:0] pick_sample(
      input logic signed [SAMPLE_W-1:0] prev);
    case ($urandom_range(0, 9))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2, 3:    return SAMPLE_W'(int'(prev) + int'($urandom_range(0, 512)) - 256);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  initial begin
    logic [STEP_W-1:0]          fixed_steps[7];
    logic [STEP_W-1:0]          step;
    logic signed [SAMPLE_W-1:0] l;
    logic signed [SAMPLE_W-1:0] r;

    fixed_steps = '{19'd4096, 19'd262144, 19'd32768, 19'd65535, 19'd65537,
                    19'd4095, 19'd262145};

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // --- directed ---
    // reset step is unity: straight pass-through, rails both ways
    send_frame(16'sh7FFF, 16'sh8000);
    send_frame(16'sh8000, 16'sh7FFF);
    send_frame(16'sh0000, -16'sd1);
    send_frame(-16'sd1, 16'sh0000);
    end_phase();

    // step 1/16: first beat only primes history, then 16 beats of full swing
    set_step(19'd4096);
    send_frame(16'sh8000, 16'sh7FFF);
    send_frame(16'sh7FFF, 16'sh8000);
    send_frame(16'sh0000, 16'sh0000);
    send_frame(16'sh8000, 16'sh8000);
    end_phase();

    // widest 19-bit step: decimation, most source beats produce nothing
    set_step(19'h7FFFF);
    send_frame(16'sh1234, -16'sd4660);
    send_frame(16'sh7FFF, 16'sh7FFF);
    send_frame(16'sh8000, 16'sh8000);
    send_frame(16'sh5555, 16'shAAAA);
    send_frame(16'shAAAA, 16'sh5555);
    end_phase();

    // zero step: phase never moves, capped at 16 beats per source beat
    set_step(19'd0);
    send_frame(16'sh7FFF, 16'sh8000);
    send_frame(16'sh8000, 16'sh7FFF);
    send_frame(16'sh0001, -16'sd1);
    end_phase();

    // unity written explicitly
    set_step(ONE_Q16);
    send_frame(16'sh4000, -16'sd16384);
    send_frame(-16'sd2, 16'sh0003);
    end_phase();

    // step 1.5: two of every three source beats give one beat, the third none
    set_step(19'd98304);
    send_frame(16'sh0000, 16'sh0000);
    send_frame(16'sh0003, -16'sd3);
    send_frame(16'sh7FFF, 16'sh8000);
    send_frame(16'sh8000, 16'sh7FFF);
    end_phase();

    // --- random ---
    // idling varies by phase: none, light, heavy; last phases run flat out
    l = '0;
    r = '0;
    for (int p = 0; p < RAND_PHASES; p++) begin
      step = (p < 7) ? fixed_steps[p] : STEP_W'($urandom_range(4096, 262144));
      if (p >= RAND_PHASES - 2) gap_odds = 0;
      else gap_odds = (p % 3 == 0) ? 0 : ((p % 3 == 1) ? 6 : 2);
      set_step(step);
      // step 1/16 floods the output: hold it off while sources keep coming
      if (p == 0) want_long_hold = 1'b1;
      for (int i = 0; i < PHASE_BEATS; i++) begin
        l = pick_sample(l);
        r = pick_sample(r);
        send_frame(l, r);
      end
      end_phase();
    end

    $display("Run covered %0d source beats and %0d resampled beats over %0d step writes,",
             in_beats, out_beats, settings_used);
    $display("including unity, zero and 19-bit max steps and a %0d-cycle output hold.",
             LONG_HOLD);
    if (fail_cnt == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
